// ===== sv/sbda_pkg.sv =====
// Shared constants and cell control type for the signed binary to decimal ASCII block.
// No dependencies.
package sbda_pkg;

  localparam int ValueWidth = 32;
  localparam int NumDigits  = 10;
  localparam int DigitWidth = 4;
  localparam int CharWidth  = 7;

  localparam logic [CharWidth-1:0] CharZero  = 7'd48;
  localparam logic [CharWidth-1:0] CharMinus = 7'd45;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
  } cell_ctl_t;

endpackage

// ===== sv/signed_binary_to_decimal_ascii_top.sv =====
// After the double-dabble steps, a negative number's minus sign strobes first, then the
// digits come one per cycle after the skipped leading zeros, the last with last_char set.
// Busy stays high from each start until the last character, and a new number is taken
// only while idle: 32 double-dabble steps through the digit cell row, then 11 output steps.
// Reset (rst, synchronous) returns to idle with no strobe; the receiver cannot stall.
// Depends on sbda_pkg and sbda_bcd_cell.
module signed_binary_to_decimal_ascii_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [sbda_pkg::ValueWidth-1:0] value,
  output logic                           strobe,
  output logic [sbda_pkg::CharWidth-1:0] char_code,
  output logic                           last_char
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                          state;
  logic [sbda_pkg::ValueWidth-1:0] mag;
  logic                            neg;
  logic [4:0]                      cnt;
  logic [3:0]                      rem;
  sbda_pkg::cell_ctl_t             ctl;

  logic [sbda_pkg::DigitWidth-1:0] digits [sbda_pkg::NumDigits];
  logic [sbda_pkg::NumDigits-1:0]  carries;
  logic [sbda_pkg::DigitWidth-1:0] top_digit;

  assign top_digit = digits[sbda_pkg::NumDigits-1];
  assign busy      = (state != ST_IDLE);

  always_comb begin
    ctl.mode = sbda_pkg::CELL_HOLD;
    unique case (state)
      ST_IDLE: if (start) ctl.mode = sbda_pkg::CELL_CLEAR;
      ST_CONV: ctl.mode = sbda_pkg::CELL_DABBLE;
      ST_SKIP: if (top_digit == '0 && rem > 4'd1) ctl.mode = sbda_pkg::CELL_SHIFT;
      ST_EMIT: ctl.mode = sbda_pkg::CELL_SHIFT;
      default: ctl.mode = sbda_pkg::CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < sbda_pkg::NumDigits; i++) begin : g_cell
    if (i == 0) begin : g_low
      sbda_bcd_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .bit_in   (mag[sbda_pkg::ValueWidth-1]),
        .digit_in ('0),
        .digit    (digits[i]),
        .bit_out  (carries[i])
      );
    end else begin : g_up
      sbda_bcd_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .bit_in   (carries[i-1]),
        .digit_in (digits[i-1]),
        .digit    (digits[i]),
        .bit_out  (carries[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      strobe    <= 1'b0;
      neg       <= 1'b0;
      cnt       <= '0;
      rem       <= '0;
      mag       <= '0;
      char_code <= '0;
      last_char <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            neg   <= value[sbda_pkg::ValueWidth-1];
            mag   <= value[sbda_pkg::ValueWidth-1] ? (~value + 32'd1) : value;
            cnt   <= 5'd31;
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag <= {mag[sbda_pkg::ValueWidth-2:0], 1'b0};
          cnt <= cnt - 5'd1;
          if (cnt == '0) begin
            rem   <= 4'(sbda_pkg::NumDigits);
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (neg) begin
            strobe    <= 1'b1;
            char_code <= sbda_pkg::CharMinus;
            last_char <= 1'b0;
            neg       <= 1'b0;
          end
          if (top_digit == '0 && rem > 4'd1) begin
            rem <= rem - 4'd1;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          strobe    <= 1'b1;
          char_code <= sbda_pkg::CharZero + {3'b000, top_digit};
          last_char <= (rem == 4'd1);
          rem       <= rem - 4'd1;
          if (rem == 4'd1) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // the final character of a run leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last_char |-> !busy)
    else $error("last character while still busy");

  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    strobe && last_char |=> !strobe)
    else $error("beat after last character");

  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !strobe)
    else $error("accept did not start conversion cleanly");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && char_code == sbda_pkg::CharMinus |-> !last_char)
    else $error("minus sign flagged as last");

endmodule

// ===== sv/sbda_bcd_cell.sv =====
// One BCD digit cell of the double-dabble row: add-3 correction and bit shift,
// or whole-digit shift toward the top during output. Depends on sbda_pkg.
module sbda_bcd_cell (
  input  logic                            clk,
  input  sbda_pkg::cell_ctl_t             ctl,
  input  logic                            bit_in,
  input  logic [sbda_pkg::DigitWidth-1:0] digit_in,
  output logic [sbda_pkg::DigitWidth-1:0] digit,
  output logic                            bit_out
);

  logic [sbda_pkg::DigitWidth-1:0] corrected;

  always_comb begin
    corrected = (digit >= 4'd5) ? digit + 4'd3 : digit;
  end

  assign bit_out = corrected[sbda_pkg::DigitWidth-1];

  always_ff @(posedge clk) begin
    unique case (ctl.mode)
      sbda_pkg::CELL_HOLD:   digit <= digit;
      sbda_pkg::CELL_CLEAR:  digit <= '0;
      sbda_pkg::CELL_DABBLE: digit <= {corrected[sbda_pkg::DigitWidth-2:0], bit_in};
      sbda_pkg::CELL_SHIFT:  digit <= digit_in;
      default:               digit <= digit;
    endcase
  end

endmodule

// ===== test/testbench.sv =====
// Testbench for signed_binary_to_decimal_ascii_top: drives signed 32-bit numbers and
// checks every ASCII character beat against a behavioral decimal formatter.
// Depends on sbda_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [sbda_pkg::CharWidth-1:0] code;
    logic                           last;
  } char_beat_t;

  localparam int RandomCount = 250;
  localparam int DrainPointA = 25;
  localparam int DrainPointB = 150;
  localparam int BurstFirst  = 90;
  localparam int BurstLast   = 170;

  logic                                   clk = 1'b0;
  logic                                   rst = 1'b1;
  logic                                   start = 1'b0;
  logic signed [sbda_pkg::ValueWidth-1:0] value = '0;
  logic                                   busy;
  logic                                   strobe;
  logic [sbda_pkg::CharWidth-1:0]         char_code;
  logic                                   last_char;

  logic [sbda_pkg::ValueWidth-1:0] numbers_to_send[$];
  char_beat_t                      expected_chars[$];
  int                              numbers_total = 0;
  int                              numbers_taken = 0;
  int                              fail_count = 0;

  signed_binary_to_decimal_ascii_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .char_code (char_code),
    .last_char (last_char)
  );

  always #1 clk = ~clk;

  function automatic logic [sbda_pkg::ValueWidth-1:0] pow10(int k);
    logic [sbda_pkg::ValueWidth-1:0] p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  // Pushes the decimal text of one number, most significant character first.
  function automatic void push_decimal_text(logic [sbda_pkg::ValueWidth-1:0] raw);
    logic                            neg;
    logic [sbda_pkg::ValueWidth-1:0] mag;
    logic [3:0]                      dig[sbda_pkg::NumDigits];
    int                              nd;
    char_beat_t                      beat;
    neg = raw[sbda_pkg::ValueWidth-1];
    mag = neg ? (~raw + 32'd1) : raw;
    nd = 0;
    if (mag == 0) begin
      dig[0] = 4'd0;
      nd = 1;
    end
    while (mag != 0 && nd < sbda_pkg::NumDigits) begin
      dig[nd] = 4'(mag % 10);
      mag = mag / 10;
      nd++;
    end
    if (neg) begin
      beat.code = sbda_pkg::CharMinus;
      beat.last = 1'b0;
      expected_chars.push_back(beat);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      beat.code = sbda_pkg::CharZero + {3'b000, dig[k]};
      beat.last = (k == 0);
      expected_chars.push_back(beat);
    end
  endfunction

  function automatic logic [sbda_pkg::ValueWidth-1:0] random_number();
    int unsigned                     pick;
    int unsigned                     nd;
    logic [sbda_pkg::ValueWidth-1:0] lo;
    logic [sbda_pkg::ValueWidth-1:0] hi;
    logic [sbda_pkg::ValueWidth-1:0] v;
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      v = $urandom;
    end else if (pick <= 6) begin
      nd = $urandom_range(1, sbda_pkg::NumDigits);
      lo = pow10(nd - 1);
      hi = (nd == sbda_pkg::NumDigits) ? 32'h7FFF_FFFF : pow10(nd) - 1;
      v = $urandom_range(hi, lo);
      if ($urandom_range(0, 1) == 1) v = -v;
    end else if (pick == 7) begin
      v = pow10($urandom_range(0, sbda_pkg::NumDigits - 1)) + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1) == 1) v = -v;
    end else begin
      v = $urandom_range(0, 20);
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return v;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  // Driver: start stays high until the beat is taken, then the next number or a gap.
  always @(posedge clk) begin
    logic taken;
    logic gap;
    logic drain;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        push_decimal_text(value);
        numbers_taken++;
      end
      if (!start || taken) begin
        gap = ($urandom_range(0, 99) < 33) &&
              !(numbers_taken >= BurstFirst && numbers_taken < BurstLast);
        drain = (numbers_taken == DrainPointA || numbers_taken == DrainPointB) &&
                (expected_chars.size() != 0);
        if (numbers_to_send.size() != 0 && !gap && !drain) begin
          start <= 1'b1;
          value <= numbers_to_send.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is one character beat.
  always @(posedge clk) begin
    char_beat_t want;
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        note_failure($sformatf("unexpected char %0d last %0b", char_code, last_char));
      end else begin
        want = expected_chars.pop_front();
        if (char_code !== want.code || last_char !== want.last)
          note_failure($sformatf("char exp %0d got %0d, last exp %0b got %0b",
                                 want.code, char_code, want.last, last_char));
      end
    end
  end

  initial begin
    logic [sbda_pkg::ValueWidth-1:0] directed[$];
    directed = '{32'd0, 32'd1, -32'd1, 32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'd1000000000, -32'd1000000000,
                 32'd999999999, 32'd123456789, -32'd123456789, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'd7, -32'd9, 32'd1999999999, 32'h8000_0001,
                 32'd100000, -32'd4000321};
    foreach (directed[i]) numbers_to_send.push_back(directed[i]);
    for (int i = 0; i < RandomCount; i++) numbers_to_send.push_back(random_number());
    numbers_total = numbers_to_send.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (numbers_taken == numbers_total);
    wait (expected_chars.size() == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && expected_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sbda_pkg.sv
sv/sbda_bcd_cell.sv
sv/signed_binary_to_decimal_ascii_top.sv
test/testbench.sv
